@@ hdl/lapjd_pkg.sv @@
// ----------------------------------------------------------------------------
// lapjd_pkg: shared types and constants of the lap joint step detector
// Field widths, register codes, status codes, queue entry and result formats.
// ----------------------------------------------------------------------------
`default_nettype none

package lapjd_pkg;

    // Widths of the request and result fields.
    localparam int COORD_W   = 20;
    localparam int STEP_W    = 20;
    localparam int CONF_W    = 16;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 3;

    // Default sizing of the point store and the scan.
    localparam int DEF_MAX_POINTS = 2048;
    localparam int DEF_EDGE_GUARD = 5;
    localparam int DEF_MIN_POINTS = 20;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Confidence is a Q1.15 quotient: fifteen quotient bits, 1.0 as its own code.
    localparam int              DIV_STEPS = 15;
    localparam logic [CONF_W-1:0] CONF_ONE = 16'h8000;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND      = 2'd0,
        ST_FEW_POINTS = 2'd1,
        ST_STEP_SMALL = 2'd2
    } status_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROI_X_MIN  = 3'd0,
        REG_ROI_X_MAX  = 3'd1,
        REG_ROI_Z_MIN  = 3'd2,
        REG_ROI_Z_MAX  = 3'd3,
        REG_MIN_STEP   = 3'd4,
        REG_MAX_STEP   = 3'd5
    } cfg_idx_t;

    // Configuration register file.
    typedef struct packed {
        logic signed [COORD_W-1:0] roi_x_min;
        logic signed [COORD_W-1:0] roi_x_max;
        logic signed [COORD_W-1:0] roi_z_min;
        logic signed [COORD_W-1:0] roi_z_max;
        logic        [STEP_W-1:0]  min_step;
        logic        [STEP_W-1:0]  max_step;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        roi_x_min: 20'h80000,
        roi_x_max: 20'h7FFFF,
        roi_z_min: 20'h80000,
        roi_z_max: 20'h7FFFF,
        min_step:  20'd500,
        max_step:  20'd5000
    };

    // One classified point as it travels through the queue.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] z;
        logic                      keep;
        logic                      last;
    } entry_t;

    // One result as held in the output register.
    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [COORD_W-1:0] root_x;
        logic signed [COORD_W-1:0] root_z;
        logic signed [COORD_W-1:0] left_plate_z;
        logic signed [COORD_W-1:0] right_plate_z;
        logic [STEP_W-1:0]         step_height;
        logic [CONF_W-1:0]         confidence;
    } result_t;

    // Sequencer states of the back part.
    typedef enum logic [2:0] {
        B_RUN,
        B_SCAN,
        B_EVAL,
        B_DIV,
        B_DONE
    } back_state_t;

endpackage

`default_nettype wire

@@ hdl/lapjd_if.sv @@
// ----------------------------------------------------------------------------
// lapjd_if: channel interfaces of the lap joint step detector
// Point request channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

// Profile point requests.
interface lapjd_point_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [lapjd_pkg::COORD_W-1:0] point_x;
    logic signed [lapjd_pkg::COORD_W-1:0] point_z;
    logic                                 point_ok;
    logic                                 end_of_profile;

    modport source (output valid, point_x, point_z, point_ok, end_of_profile, input ready);
    modport sink   (input valid, point_x, point_z, point_ok, end_of_profile, output ready);
endinterface

// Step detection results.
interface lapjd_result_if;
    logic                                 valid;
    logic                                 ready;
    logic [lapjd_pkg::STATUS_W-1:0]       status;
    logic signed [lapjd_pkg::COORD_W-1:0] root_x;
    logic signed [lapjd_pkg::COORD_W-1:0] root_z;
    logic signed [lapjd_pkg::COORD_W-1:0] left_plate_z;
    logic signed [lapjd_pkg::COORD_W-1:0] right_plate_z;
    logic [lapjd_pkg::STEP_W-1:0]         step_height;
    logic [lapjd_pkg::CONF_W-1:0]         confidence;

    modport source (output valid, status, root_x, root_z, left_plate_z, right_plate_z,
                    step_height, confidence, input ready);
    modport sink   (input valid, status, root_x, root_z, left_plate_z, right_plate_z,
                    step_height, confidence, output ready);
endinterface

// Configuration register writes.
interface lapjd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lapjd_pkg::CFG_IDX_W-1:0] index;
    logic [lapjd_pkg::COORD_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/lap_joint_step_detector_top.sv @@
// ----------------------------------------------------------------------------
// lap_joint_step_detector_top: lap joint step edge detector
// Finds the largest neighbor z step of one laser profile and reports the
// joint root, plate heights, step height and confidence.
// ----------------------------------------------------------------------------
// Usage:
// The point channel takes one profile point per request; end_of_profile marks
// the last point. Each profile gives exactly one request on the result channel,
// none for other points. The configuration channel writes the window and step
// registers by index and is always ready; write it only while no profile is
// in flight.
// Throughput: while a profile streams in and the queue is not empty, one point
// is taken per cycle and stored if kept. At the end of a profile the point
// store is read one entry per cycle over N - 2*EDGE_GUARD + 1 entries (N kept
// points), then the block evaluates the largest step, runs the bit-serial
// divider when the confidence is below 1.0, and loads the output register;
// the point store has a single read port. Meanwhile the two-entry queue
// absorbs points, after which the point channel stalls.
// A result waits in its output register while the receiver stalls; storing
// of the next profile goes on until that profile ends too. Reset clears the
// point count, the queue and the output valid; the store needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module lap_joint_step_detector_top #(
    parameter int MAX_POINTS = lapjd_pkg::DEF_MAX_POINTS,
    parameter int EDGE_GUARD = lapjd_pkg::DEF_EDGE_GUARD,
    parameter int MIN_POINTS = lapjd_pkg::DEF_MIN_POINTS
) (
    input  logic          clk,
    input  logic          rst_n,
    lapjd_cfg_if.sink     cfg,
    lapjd_point_if.sink   point,
    lapjd_result_if.source result
);

    lapjd_pkg::cfg_t   cfg_reg;
    logic              q_push, q_full, q_pop, q_empty;
    lapjd_pkg::entry_t q_wdata, q_rdata;

    // Configuration registers; unknown indexes are ignored.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= lapjd_pkg::CFG_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                lapjd_pkg::REG_ROI_X_MIN: cfg_reg.roi_x_min <= cfg.data;
                lapjd_pkg::REG_ROI_X_MAX: cfg_reg.roi_x_max <= cfg.data;
                lapjd_pkg::REG_ROI_Z_MIN: cfg_reg.roi_z_min <= cfg.data;
                lapjd_pkg::REG_ROI_Z_MAX: cfg_reg.roi_z_max <= cfg.data;
                lapjd_pkg::REG_MIN_STEP:  cfg_reg.min_step  <= cfg.data;
                lapjd_pkg::REG_MAX_STEP:  cfg_reg.max_step  <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    // Front: intake and window filter.
    lapjd_front u_front (
        .cfg    (cfg_reg),
        .point  (point),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_wdata)
    );

    // Queue between front and back.
    lapjd_queue #(
        .DEPTH (lapjd_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    // Back: store, scan, divide, deliver.
    lapjd_back #(
        .MAX_POINTS (MAX_POINTS),
        .EDGE_GUARD (EDGE_GUARD),
        .MIN_POINTS (MIN_POINTS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule

`default_nettype wire

@@ hdl/lapjd_front.sv @@
// ----------------------------------------------------------------------------
// lapjd_front: point intake and region filter
// Accepts point requests while the queue has room and tags each one as kept
// or dropped against the configured x/z window.
// ----------------------------------------------------------------------------
`default_nettype none

module lapjd_front (
    input  lapjd_pkg::cfg_t   cfg,
    lapjd_point_if.sink       point,
    input  logic              q_full,
    output logic              q_push,
    output lapjd_pkg::entry_t q_data
);

    logic in_window;

    // A point is kept when the sensor marked it valid and it lies in the window.
    assign in_window = ($signed(point.point_x) >= cfg.roi_x_min) &&
                       ($signed(point.point_x) <= cfg.roi_x_max) &&
                       ($signed(point.point_z) >= cfg.roi_z_min) &&
                       ($signed(point.point_z) <= cfg.roi_z_max);

    // Requests pass straight into the queue whenever it has room.
    assign point.ready = !q_full;
    assign q_push      = point.valid && !q_full;

    assign q_data.x    = point.point_x;
    assign q_data.z    = point.point_z;
    assign q_data.keep = point.point_ok && in_window;
    assign q_data.last = point.end_of_profile;

endmodule

`default_nettype wire

@@ hdl/lapjd_queue.sv @@
// ----------------------------------------------------------------------------
// lapjd_queue: short queue between the front and the back
// A small circular buffer of classified points so that intake and the
// end-of-profile scan can stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module lapjd_queue #(
    parameter int DEPTH = lapjd_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lapjd_pkg::entry_t wdata,
    output logic              full,
    input  logic              pop,
    output lapjd_pkg::entry_t rdata,
    output logic              empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    lapjd_pkg::entry_t buf_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     fill_reg, fill_next;
    logic              do_push, do_pop;

    assign full    = (fill_reg == CW'(DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = buf_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            buf_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

@@ hdl/lapjd_back.sv @@
// ----------------------------------------------------------------------------
// lapjd_back: point store, step scan and confidence divider
// Writes kept points into the point store, and at the end of a profile scans
// neighbor pairs for the largest z step, divides for the confidence and loads
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lapjd_back #(
    parameter int MAX_POINTS = lapjd_pkg::DEF_MAX_POINTS,
    parameter int EDGE_GUARD = lapjd_pkg::DEF_EDGE_GUARD,
    parameter int MIN_POINTS = lapjd_pkg::DEF_MIN_POINTS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lapjd_pkg::cfg_t   cfg,
    input  logic              q_empty,
    input  lapjd_pkg::entry_t q_data,
    output logic              q_pop,
    lapjd_result_if.source    result
);

    localparam int AW  = $clog2(MAX_POINTS);
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int DCW = $clog2(lapjd_pkg::DIV_STEPS + 1);
    localparam int XW  = lapjd_pkg::COORD_W;
    localparam int SW  = lapjd_pkg::STEP_W;
    localparam int QW  = lapjd_pkg::DIV_STEPS;

    // Floor of the midpoint of two signed coordinates.
    function automatic logic signed [XW-1:0] mid_of(input logic signed [XW-1:0] a,
                                                    input logic signed [XW-1:0] b);
        logic signed [XW:0] s;
        begin
            s = {a[XW-1], a} + {b[XW-1], b};
            return s[XW:1];
        end
    endfunction

    // Smaller of two signed coordinates.
    function automatic logic signed [XW-1:0] min_of(input logic signed [XW-1:0] a,
                                                    input logic signed [XW-1:0] b);
        begin
            return (a < b) ? a : b;
        end
    endfunction

    // Sequencer and counters.
    lapjd_pkg::back_state_t state_reg, state_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [AW-1:0]          scan_end_reg, scan_end_next;
    logic [AW-1:0]          rd_addr_reg, rd_addr_next;
    logic [AW-1:0]          rd_addr_d_reg, rd_addr_d_next;
    logic                   rd_vld_reg, rd_vld_next;
    logic                   iss_done_reg, iss_done_next;
    logic [DCW-1:0]         div_cnt_reg, div_cnt_next;
    logic                   out_vld_reg, out_vld_next;

    // Datapath registers.
    logic [2*XW-1:0]        store_mem [MAX_POINTS];
    logic [2*XW-1:0]        mem_q_reg;
    logic signed [XW-1:0]   x0_reg, z0_reg, x1_reg, z1_reg, zr_reg;
    logic signed [XW-1:0]   prev_x_reg, prev_x_next;
    logic signed [XW-1:0]   prev_z_reg, prev_z_next;
    logic [SW-1:0]          best_reg, best_next;
    logic signed [XW-1:0]   root_x_reg, root_x_next;
    logic signed [XW-1:0]   root_z_reg, root_z_next;
    logic [SW-1:0]          rem_reg, rem_next;
    logic [QW-1:0]          quo_reg, quo_next;
    logic [lapjd_pkg::CONF_W-1:0] conf_reg, conf_next;
    lapjd_pkg::status_t     status_reg, status_next;
    lapjd_pkg::result_t     out_reg, out_next;

    // Combinational helpers.
    logic                   wr_en, rd_en;
    logic [31:0]            n_new;
    logic signed [XW-1:0]   cur_x, cur_z;
    logic signed [XW:0]     dz, dz_neg;
    logic [SW-1:0]          step_mag;
    logic [SW:0]            rem_dbl;
    logic                   quo_bit;

    assign cur_x = mem_q_reg[2*XW-1:XW];
    assign cur_z = mem_q_reg[XW-1:0];

    // Absolute z step between the previous and the current scanned point.
    assign dz       = {cur_z[XW-1], cur_z} - {prev_z_reg[XW-1], prev_z_reg};
    assign dz_neg   = -dz;
    assign step_mag = dz[XW] ? dz_neg[SW-1:0] : dz[SW-1:0];

    // One restoring division step.
    assign rem_dbl = {rem_reg, 1'b0};
    assign quo_bit = (rem_dbl >= {1'b0, cfg.max_step});

    // Sequencer: store, scan, evaluate, divide, deliver.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        scan_end_next  = scan_end_reg;
        rd_addr_next   = rd_addr_reg;
        rd_addr_d_next = rd_addr_d_reg;
        rd_vld_next    = 1'b0;
        iss_done_next  = iss_done_reg;
        div_cnt_next   = div_cnt_reg;
        prev_x_next    = prev_x_reg;
        prev_z_next    = prev_z_reg;
        best_next      = best_reg;
        root_x_next    = root_x_reg;
        root_z_next    = root_z_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        conf_next      = conf_reg;
        status_next    = status_reg;
        out_next       = out_reg;
        out_vld_next   = out_vld_reg && !result.ready;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        q_pop          = 1'b0;
        n_new          = 32'(cnt_reg);

        unique case (state_reg)
            lapjd_pkg::B_RUN:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    wr_en = q_data.keep && (cnt_reg < CW'(MAX_POINTS));
                    n_new = 32'(cnt_reg) + 32'(wr_en);
                    if (q_data.last)
                    begin
                        // Profile closed: set up the scan over the stored points.
                        cnt_next      = '0;
                        best_next     = '0;
                        root_x_next   = mid_of(x0_reg, x1_reg);
                        root_z_next   = min_of(z0_reg, z1_reg);
                        rd_addr_next  = AW'(EDGE_GUARD);
                        iss_done_next = 1'b0;
                        scan_end_next = AW'(n_new - 32'(EDGE_GUARD));
                        if (n_new < 32'(MIN_POINTS))
                        begin
                            status_next = lapjd_pkg::ST_FEW_POINTS;
                            state_next  = lapjd_pkg::B_DONE;
                        end
                        else if (32'(2 * EDGE_GUARD) >= n_new)
                        begin
                            state_next = lapjd_pkg::B_EVAL;
                        end
                        else
                        begin
                            state_next = lapjd_pkg::B_SCAN;
                        end
                    end
                    else
                    begin
                        cnt_next = CW'(n_new);
                    end
                end
            end

            lapjd_pkg::B_SCAN:
            begin
                // Read one stored point per cycle.
                if (!iss_done_reg)
                begin
                    rd_en          = 1'b1;
                    rd_addr_d_next = rd_addr_reg;
                    if (rd_addr_reg == scan_end_reg)
                    begin
                        iss_done_next = 1'b1;
                    end
                    else
                    begin
                        rd_addr_next = rd_addr_reg + 1'b1;
                    end
                end
                rd_vld_next = rd_en;

                // Compare each neighbor pair as its second point returns.
                if (rd_vld_reg)
                begin
                    prev_x_next = cur_x;
                    prev_z_next = cur_z;
                    if ((rd_addr_d_reg != AW'(EDGE_GUARD)) && (step_mag > best_reg))
                    begin
                        best_next   = step_mag;
                        root_x_next = mid_of(prev_x_reg, cur_x);
                        root_z_next = min_of(prev_z_reg, cur_z);
                    end
                    if (rd_addr_d_reg == scan_end_reg)
                    begin
                        state_next = lapjd_pkg::B_EVAL;
                    end
                end
            end

            lapjd_pkg::B_EVAL:
            begin
                if (best_reg < cfg.min_step)
                begin
                    status_next = lapjd_pkg::ST_STEP_SMALL;
                    state_next  = lapjd_pkg::B_DONE;
                end
                else if (best_reg >= cfg.max_step)
                begin
                    status_next = lapjd_pkg::ST_FOUND;
                    conf_next   = lapjd_pkg::CONF_ONE;
                    state_next  = lapjd_pkg::B_DONE;
                end
                else
                begin
                    status_next  = lapjd_pkg::ST_FOUND;
                    rem_next     = best_reg;
                    quo_next     = '0;
                    div_cnt_next = '0;
                    state_next   = lapjd_pkg::B_DIV;
                end
            end

            lapjd_pkg::B_DIV:
            begin
                // One quotient bit of step * 2^15 / max_step per cycle.
                rem_next     = quo_bit ? SW'(rem_dbl - {1'b0, cfg.max_step}) : rem_dbl[SW-1:0];
                quo_next     = {quo_reg[QW-2:0], quo_bit};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DCW'(lapjd_pkg::DIV_STEPS - 1))
                begin
                    conf_next  = lapjd_pkg::CONF_W'(quo_next);
                    state_next = lapjd_pkg::B_DONE;
                end
            end

            lapjd_pkg::B_DONE:
            begin
                // Load the output register once the previous result is gone.
                if (!out_vld_reg || result.ready)
                begin
                    out_next        = '0;
                    out_next.status = status_reg;
                    if (status_reg != lapjd_pkg::ST_FEW_POINTS)
                    begin
                        out_next.step_height = best_reg;
                    end
                    if (status_reg == lapjd_pkg::ST_FOUND)
                    begin
                        out_next.root_x        = root_x_reg;
                        out_next.root_z        = root_z_reg;
                        out_next.left_plate_z  = z0_reg;
                        out_next.right_plate_z = zr_reg;
                        out_next.confidence    = conf_reg;
                    end
                    out_vld_next = 1'b1;
                    state_next   = lapjd_pkg::B_RUN;
                end
            end

            default:
            begin
                state_next = lapjd_pkg::B_RUN;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lapjd_pkg::B_RUN;
            cnt_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            iss_done_reg <= 1'b0;
            div_cnt_reg  <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            rd_vld_reg   <= rd_vld_next;
            iss_done_reg <= iss_done_next;
            div_cnt_reg  <= div_cnt_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        scan_end_reg  <= scan_end_next;
        rd_addr_reg   <= rd_addr_next;
        rd_addr_d_reg <= rd_addr_d_next;
        prev_x_reg    <= prev_x_next;
        prev_z_reg    <= prev_z_next;
        best_reg      <= best_next;
        root_x_reg    <= root_x_next;
        root_z_reg    <= root_z_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        conf_reg      <= conf_next;
        status_reg    <= status_next;
        out_reg       <= out_next;
    end

    // First two points and the latest point of the profile.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            zr_reg <= q_data.z;
            if (cnt_reg == CW'(0))
            begin
                x0_reg <= q_data.x;
                z0_reg <= q_data.z;
            end
            if (cnt_reg == CW'(1))
            begin
                x1_reg <= q_data.x;
                z1_reg <= q_data.z;
            end
        end
    end

    // Point store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[cnt_reg[AW-1:0]] <= {q_data.x, q_data.z};
        end
        if (rd_en)
        begin
            mem_q_reg <= store_mem[rd_addr_reg];
        end
    end

    // Result channel.
    assign result.valid         = out_vld_reg;
    assign result.status        = out_reg.status;
    assign result.root_x        = out_reg.root_x;
    assign result.root_z        = out_reg.root_z;
    assign result.left_plate_z  = out_reg.left_plate_z;
    assign result.right_plate_z = out_reg.right_plate_z;
    assign result.step_height   = out_reg.step_height;
    assign result.confidence    = out_reg.confidence;

endmodule

`default_nettype wire

@@ hdl/lapjd_checker.sv @@
// ----------------------------------------------------------------------------
// lapjd_checker: port-level checks of the lap joint step detector
// Watches the result channel for handshake holding and field consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module lapjd_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic [lapjd_pkg::STATUS_W-1:0]       status,
    input logic signed [lapjd_pkg::COORD_W-1:0] root_x,
    input logic signed [lapjd_pkg::COORD_W-1:0] root_z,
    input logic signed [lapjd_pkg::COORD_W-1:0] left_plate_z,
    input logic signed [lapjd_pkg::COORD_W-1:0] right_plate_z,
    input logic [lapjd_pkg::STEP_W-1:0]         step_height,
    input logic [lapjd_pkg::CONF_W-1:0]         confidence
);

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped while stalled");

    // A stalled result keeps its status, root, step height and confidence.
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(status) && $stable(root_x) && $stable(root_z) &&
            $stable(step_height) && $stable(confidence))
        else $error("result fields changed while stalled");

    // Geometry and confidence are zero unless a step was found.
    a_zero_unless_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != lapjd_pkg::ST_FOUND) |->
            (root_x == '0) && (root_z == '0) && (left_plate_z == '0) &&
            (right_plate_z == '0) && (confidence == '0))
        else $error("nonzero field in a result without a step");

    // Confidence never exceeds 1.0, and a short profile reports no step.
    a_conf_and_short: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (confidence <= lapjd_pkg::CONF_ONE) &&
            ((status != lapjd_pkg::ST_FEW_POINTS) || (step_height == '0)))
        else $error("confidence above 1.0 or step reported for a short profile");

endmodule

bind lap_joint_step_detector_top lapjd_checker u_lapjd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .status        (result.status),
    .root_x        (result.root_x),
    .root_z        (result.root_z),
    .left_plate_z  (result.left_plate_z),
    .right_plate_z (result.right_plate_z),
    .step_height   (result.step_height),
    .confidence    (result.confidence)
);

`default_nettype wire

@@ test/lap_joint_step_detector_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lap_joint_step_detector_checker: result checker of the lap joint detector
// Watches the configuration, point and result channels, keeps its own copy
// of the window registers and of the kept points of the current profile,
// works out the step result of every profile and compares it field by field
// with what the block delivers.
// ----------------------------------------------------------------------------

module lap_joint_step_detector_checker #(
    parameter int MAX_POINTS = lapjd_pkg::DEF_MAX_POINTS,
    parameter int EDGE_GUARD = lapjd_pkg::DEF_EDGE_GUARD,
    parameter int MIN_POINTS = lapjd_pkg::DEF_MIN_POINTS
) (
    input  logic     clk,
    input  logic     rst_n,
    lapjd_cfg_if     cfg,
    lapjd_point_if   point,
    lapjd_result_if  result,
    output int       fail_count,
    output int       results_owed
);

    // Window and step thresholds as last written.
    logic signed [lapjd_pkg::COORD_W-1:0] win_x_lo;
    logic signed [lapjd_pkg::COORD_W-1:0] win_x_hi;
    logic signed [lapjd_pkg::COORD_W-1:0] win_z_lo;
    logic signed [lapjd_pkg::COORD_W-1:0] win_z_hi;
    logic [lapjd_pkg::STEP_W-1:0]         step_floor;
    logic [lapjd_pkg::STEP_W-1:0]         step_full;

    // Kept points of the profile in progress.
    logic signed [lapjd_pkg::COORD_W-1:0] prof_x [MAX_POINTS];
    logic signed [lapjd_pkg::COORD_W-1:0] prof_z [MAX_POINTS];
    int                                   kept;

    lapjd_pkg::result_t owed_results [$];
    lapjd_pkg::result_t want;
    lapjd_pkg::result_t fresh;
    int                 results_seen;

    // Applies one register write; unknown indexes change nothing.
    function automatic void apply_write(input logic [lapjd_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [lapjd_pkg::COORD_W-1:0] data);
        case (idx)
            lapjd_pkg::REG_ROI_X_MIN: win_x_lo = data;
            lapjd_pkg::REG_ROI_X_MAX: win_x_hi = data;
            lapjd_pkg::REG_ROI_Z_MIN: win_z_lo = data;
            lapjd_pkg::REG_ROI_Z_MAX: win_z_hi = data;
            lapjd_pkg::REG_MIN_STEP:  step_floor = data;
            lapjd_pkg::REG_MAX_STEP:  step_full = data;
            default: ;
        endcase
    endfunction

    // Filters one point into the profile; on the last point scans the profile
    // for the largest neighbor step and returns 1 with the step result.
    function automatic bit absorb_point(input logic signed [lapjd_pkg::COORD_W-1:0] px,
                                        input logic signed [lapjd_pkg::COORD_W-1:0] pz,
                                        input logic ok, input logic last,
                                        output lapjd_pkg::result_t res);
        int     n;
        int     best;
        int     bi;
        int     d;
        int     sum;
        longint ratio;

        res = '0;
        if (ok && px >= win_x_lo && px <= win_x_hi && pz >= win_z_lo && pz <= win_z_hi
            && kept < MAX_POINTS)
        begin
            prof_x[kept] = px;
            prof_z[kept] = pz;
            kept++;
        end
        if (!last)
            return 1'b0;

        n = kept;
        kept = 0;
        if (n < MIN_POINTS || n < 2)
        begin
            res.status = lapjd_pkg::ST_FEW_POINTS;
            return 1'b1;
        end

        // Largest absolute step inside the guard band; the first one wins a tie.
        best = 0;
        bi = 0;
        for (int i = EDGE_GUARD; i + EDGE_GUARD < n; i++)
        begin
            d = int'(prof_z[i+1]) - int'(prof_z[i]);
            if (d < 0)
                d = -d;
            if (d > best)
            begin
                best = d;
                bi = i;
            end
        end

        res.step_height = best[lapjd_pkg::STEP_W-1:0];
        if (best < int'(step_floor))
        begin
            res.status = lapjd_pkg::ST_STEP_SMALL;
            return 1'b1;
        end

        res.status = lapjd_pkg::ST_FOUND;
        sum = int'(prof_x[bi]) + int'(prof_x[bi+1]);
        res.root_x = lapjd_pkg::COORD_W'(sum >>> 1);
        res.root_z = (prof_z[bi] < prof_z[bi+1]) ? prof_z[bi] : prof_z[bi+1];
        res.left_plate_z = prof_z[0];
        res.right_plate_z = prof_z[n-1];
        if (best >= int'(step_full))
        begin
            res.confidence = lapjd_pkg::CONF_ONE;
        end
        else
        begin
            ratio = (longint'(best) * 32768) / longint'(step_full);
            res.confidence = lapjd_pkg::CONF_W'(ratio);
        end
        return 1'b1;
    endfunction

    // Counts a wrong field and reports the first few.
    function automatic void check_field(input string name, input logic [19:0] exp_v,
                                        input logic [19:0] got_v);
        if (exp_v !== got_v)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("result %0d %s: expected %h, got %h", results_seen, name,
                         exp_v, got_v);
        end
    endfunction

    // Register writes, result checks and point prediction, in that order.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept = 0;
            win_x_lo = lapjd_pkg::CFG_RESET.roi_x_min;
            win_x_hi = lapjd_pkg::CFG_RESET.roi_x_max;
            win_z_lo = lapjd_pkg::CFG_RESET.roi_z_min;
            win_z_hi = lapjd_pkg::CFG_RESET.roi_z_max;
            step_floor = lapjd_pkg::CFG_RESET.min_step;
            step_full = lapjd_pkg::CFG_RESET.max_step;
            owed_results.delete();
            results_owed = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                apply_write(cfg.index, cfg.data);

            if (result.valid && result.ready)
            begin
                results_seen++;
                if (owed_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result %0d arrived with none owed, status %0d",
                                 results_seen, result.status);
                end
                else
                begin
                    want = owed_results.pop_front();
                    check_field("status", 20'(want.status), 20'(result.status));
                    check_field("root_x", want.root_x, result.root_x);
                    check_field("root_z", want.root_z, result.root_z);
                    check_field("left_plate_z", want.left_plate_z, result.left_plate_z);
                    check_field("right_plate_z", want.right_plate_z, result.right_plate_z);
                    check_field("step_height", want.step_height, result.step_height);
                    check_field("confidence", 20'(want.confidence), 20'(result.confidence));
                end
            end

            // A closing point queues its predicted result behind the others.
            if (point.valid && point.ready)
            begin
                if (absorb_point(point.point_x, point.point_z, point.point_ok,
                                 point.end_of_profile, fresh))
                    owed_results = {owed_results, fresh};
            end

            results_owed = owed_results.size();
        end
    end

endmodule

@@ test/lap_joint_step_detector_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lap_joint_step_detector_top_tb: testbench of the lap joint step detector
// Streams directed and random laser profiles through the point channel under
// several window and step settings, with random gaps on both channels and one
// long result stall, and lets the checker compare every step result.
// ----------------------------------------------------------------------------

module lap_joint_step_detector_top_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 1000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int PHASE_ITEMS    = 245;
    localparam int MIN_PROFILES   = 40;
    localparam int COORD_MIN      = -524288;
    localparam int COORD_MAX      = 524287;
    localparam int STEP_MAX       = 1048575;

    // Idle modes of the sender and the receiver.
    localparam int MODE_RECV_SLOW = 0;
    localparam int MODE_SEND_SLOW = 1;
    localparam int MODE_NO_IDLE   = 2;

    // Register index that decodes to nothing.
    localparam logic [lapjd_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    int mismatch_count;
    int results_owed;
    int quiet_cycles;
    int send_idle_pct;
    int recv_idle_pct;
    int items_sent;
    int profiles_done;
    bit hold_request;
    bit hold_done;

    // Window in force, used to aim the generated points.
    int win_x_lo = COORD_MIN;
    int win_x_hi = COORD_MAX;
    int win_z_lo = COORD_MIN;
    int win_z_hi = COORD_MAX;

    lapjd_cfg_if    cfg_ch ();
    lapjd_point_if  point_ch ();
    lapjd_result_if result_ch ();

    lap_joint_step_detector_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .point  (point_ch),
        .result (result_ch)
    );

    lap_joint_step_detector_checker profile_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_ch),
        .point        (point_ch),
        .result       (result_ch),
        .fail_count   (mismatch_count),
        .results_owed (results_owed)
    );

    // Clock, 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Ends the run when no channel moves a request for too long.
    always @(posedge clk)
    begin
        if ((point_ch.valid && point_ch.ready) || (result_ch.valid && result_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("lap_joint_step_detector_top: mismatch");
            $finish;
        end
    end

    // Result receiver: random stalls, plus one long hold when asked for.
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Idle rates: sender light and receiver heavy, then swapped, then none.
    function automatic void set_mode(input int mode);
        case (mode)
            MODE_RECV_SLOW:
            begin
                send_idle_pct = 11;
                recv_idle_pct = 50;
            end
            MODE_SEND_SLOW:
            begin
                send_idle_pct = 50;
                recv_idle_pct = 11;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endfunction

    function automatic int rand_in(input int lo, input int hi);
        return lo + int'($urandom_range(32'(hi - lo)));
    endfunction

    function automatic int clip(input int v, input int lo, input int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    // Offers one point request, with random gaps, and waits for it to be taken.
    task automatic send_point(input int x, input int z, input bit ok, input bit last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            point_ch.valid <= 1'b0;
            @(posedge clk);
        end
        point_ch.valid <= 1'b1;
        point_ch.point_x <= lapjd_pkg::COORD_W'(x);
        point_ch.point_z <= lapjd_pkg::COORD_W'(z);
        point_ch.point_ok <= ok;
        point_ch.end_of_profile <= last;
        @(posedge clk);
        while (!point_ch.ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic write_reg(input logic [lapjd_pkg::CFG_IDX_W-1:0] idx, input int value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= lapjd_pkg::COORD_W'(value);
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
    endtask

    // Writes every register, and one unused index that must change nothing.
    task automatic load_regs(input int x_lo, input int x_hi, input int z_lo, input int z_hi,
                             input int floor_v, input int full_v);
        write_reg(lapjd_pkg::REG_ROI_X_MIN, x_lo);
        write_reg(lapjd_pkg::REG_ROI_X_MAX, x_hi);
        write_reg(lapjd_pkg::REG_ROI_Z_MIN, z_lo);
        write_reg(REG_SPARE, rand_in(0, STEP_MAX));
        write_reg(lapjd_pkg::REG_ROI_Z_MAX, z_hi);
        write_reg(lapjd_pkg::REG_MIN_STEP, floor_v);
        write_reg(lapjd_pkg::REG_MAX_STEP, full_v);
        cfg_ch.valid <= 1'b0;
        win_x_lo = x_lo;
        win_x_hi = x_hi;
        win_z_lo = z_lo;
        win_z_hi = z_hi;
    endtask

    // Waits until every owed result has come and the block has gone quiet.
    task automatic settle();
        point_ch.valid <= 1'b0;
        do @(negedge clk); while (results_owed != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One random profile: mostly two plates with a step and a few stray
    // points, sometimes scattered points over the whole coordinate range.
    task automatic random_profile();
        int pick;
        int n;
        int kind;
        int step_at;
        int x0;
        int pitch;
        int z_left;
        int z_right;
        int x;
        int z;
        bit ok;

        pick = int'($urandom_range(99));
        n = (pick < 15) ? int'($urandom_range(19, 1)) :
            (pick < 85) ? int'($urandom_range(45, 20)) : int'($urandom_range(120, 46));
        kind = int'($urandom_range(9));
        step_at = int'($urandom_range(32'(n - 1)));
        x0 = rand_in(win_x_lo, win_x_hi);
        pitch = int'($urandom_range(2000, 1));
        z_left = rand_in(win_z_lo, win_z_hi);
        if ($urandom_range(1))
            z_right = rand_in(win_z_lo, win_z_hi);
        else
            z_right = clip(z_left + rand_in(-3000, 3000), win_z_lo, win_z_hi);

        for (int i = 0; i < n; i++)
        begin
            if (kind < 2)
            begin
                x = rand_in(COORD_MIN, COORD_MAX);
                z = rand_in(COORD_MIN, COORD_MAX);
                ok = ($urandom_range(9) != 0);
            end
            else
            begin
                x = clip(x0 + i * pitch, win_x_lo, win_x_hi);
                z = clip(((i < step_at) ? z_left : z_right) + rand_in(-40, 40),
                         win_z_lo, win_z_hi);
                ok = 1'b1;
                if ($urandom_range(99) < 6)
                begin
                    case ($urandom_range(2))
                        0: ok = 1'b0;
                        1: x = rand_in(COORD_MIN, COORD_MAX);
                        default: z = rand_in(COORD_MIN, COORD_MAX);
                    endcase
                end
            end
            send_point(x, z, ok, i == n - 1);
        end
        profiles_done++;
    endtask

    task automatic run_random(input int goal);
        int start;

        start = items_sent;
        while (items_sent - start < goal) random_profile();
    endtask

    // Stimulus and verdict.
    initial
    begin
        point_ch.valid <= 1'b0;
        point_ch.point_x <= '0;
        point_ch.point_z <= '0;
        point_ch.point_ok <= 1'b0;
        point_ch.end_of_profile <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= lapjd_pkg::REG_ROI_X_MIN;
        cfg_ch.data <= '0;
        set_mode(MODE_RECV_SLOW);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Too few points, coordinate extremes, and a rejected closing point.
        send_point(COORD_MIN, COORD_MAX, 1'b1, 1'b0);
        send_point(COORD_MAX, COORD_MIN, 1'b1, 1'b0);
        send_point(0, 0, 1'b0, 1'b0);
        send_point(12345, -1, 1'b0, 1'b1);

        // Exactly the minimum count: two equal steps inside the guard band,
        // the first one falling, bigger steps outside, odd negative x sum.
        for (int i = 0; i < 20; i++)
            send_point(-10 - 3 * i,
                       (i == 1 || i == 17) ? 9000 : (i >= 8 && i <= 11) ? -700 : 0,
                       1'b1, i == 19);
        run_random(PHASE_ITEMS);

        // Narrow window; the receiver holds off long enough to stall the input.
        settle();
        load_regs(-20000, 20000, -30000, 30000, 200, 4000);
        hold_request = 1'b1;
        run_random(PHASE_ITEMS);

        // Smallest thresholds: almost every step gives full confidence.
        settle();
        set_mode(MODE_SEND_SLOW);
        load_regs(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 1, 1);
        run_random(PHASE_ITEMS);

        // Largest thresholds, met only by a step across the whole z range.
        settle();
        load_regs(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, STEP_MAX, STEP_MAX);
        for (int i = 0; i < 20; i++)
            send_point(i, (i < 10) ? COORD_MIN : COORD_MAX, 1'b1, i == 19);
        run_random(PHASE_ITEMS);

        // Zero thresholds: a flat profile reports its first pair at full
        // confidence.
        settle();
        set_mode(MODE_NO_IDLE);
        load_regs(0, COORD_MAX, COORD_MIN, 0, 0, 0);
        for (int i = 0; i < 25; i++)
            send_point(100 + i, -7, 1'b1, i == 24);
        run_random(PHASE_ITEMS);

        // Reset values again.
        settle();
        load_regs(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 500, 5000);
        run_random(PHASE_ITEMS);
        while (profiles_done < MIN_PROFILES) random_profile();

        settle();
        if (mismatch_count == 0 && results_owed == 0)
            $display("lap_joint_step_detector_top: match");
        else
            $display("lap_joint_step_detector_top: mismatch");
        $finish;
    end

endmodule
